@@ sv/bbad_pkg.sv @@
// shared types and memory map constants for the banked bus address decoder
`timescale 1ns / 1ps

package bbad_pkg;

    typedef enum logic [3:0] {
        REGION_WORK     = 4'd0,
        REGION_SPRITE   = 4'd1,
        REGION_FG       = 4'd2,
        REGION_BG       = 4'd3,
        REGION_PAL_A    = 4'd4,
        REGION_PAL_B    = 4'd5,
        REGION_ROM      = 4'd6,
        REGION_INTERNAL = 4'd7,
        REGION_UNMAPPED = 4'd8
    } t_region;

    typedef enum logic {
        ACTION_READ  = 1'b0,
        ACTION_WRITE = 1'b1
    } t_action;

    // configuration register indexes
    localparam logic CFG_DIP_A = 1'b0;
    localparam logic CFG_DIP_B = 1'b1;

    // memory map
    localparam logic [15:0] ADDR_SPRITE_BASE = 16'h1E00;
    localparam logic [15:0] ADDR_FG_BASE     = 16'h2000;
    localparam logic [15:0] ADDR_BG_BASE     = 16'h2800;
    localparam logic [15:0] ADDR_IO_BASE     = 16'h3000;
    localparam logic [15:0] ADDR_SYSTEM      = 16'h3000;
    localparam logic [15:0] ADDR_PLAYER_ONE  = 16'h3001;
    localparam logic [15:0] ADDR_PLAYER_TWO  = 16'h3002;
    localparam logic [15:0] ADDR_DIP_A       = 16'h3003;
    localparam logic [15:0] ADDR_DIP_B       = 16'h3004;
    localparam logic [15:0] ADDR_PAL_A_BASE  = 16'h3800;
    localparam logic [15:0] ADDR_PAL_B_BASE  = 16'h3900;
    localparam logic [15:0] ADDR_SOUND_LATCH = 16'h3A00;
    localparam logic [15:0] ADDR_SCROLL_X_LO = 16'h3B08;
    localparam logic [15:0] ADDR_SCROLL_X_HI = 16'h3B09;
    localparam logic [15:0] ADDR_SCROLL_Y_LO = 16'h3B0A;
    localparam logic [15:0] ADDR_SCROLL_Y_HI = 16'h3B0B;
    localparam logic [15:0] ADDR_WATCHDOG    = 16'h3C00;
    localparam logic [15:0] ADDR_FLIP        = 16'h3D00;
    localparam logic [15:0] ADDR_COIN_A      = 16'h3D02;
    localparam logic [15:0] ADDR_COIN_B      = 16'h3D03;
    localparam logic [15:0] ADDR_BANK        = 16'h3E00;
    localparam logic [15:0] ADDR_BANKED_ROM  = 16'h4000;
    localparam logic [15:0] ADDR_FIXED_ROM   = 16'h6000;

    localparam logic [16:0] ROM_BANK_BASE    = 17'h10000;
    localparam logic [7:0]  UNMAPPED_DATA    = 8'hFF;

    typedef struct packed {
        t_action     action;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
        logic [7:0]  system_port;
        logic [7:0]  player_one_port;
        logic [7:0]  player_two_port;
    } t_item;

    typedef struct packed {
        logic [7:0]  bank;
        logic [15:0] scroll_x;
        logic [15:0] scroll_y;
        logic        flip;
        logic [7:0]  latch;
    } t_state;

    typedef struct packed {
        t_region     region;
        logic [16:0] region_offset;
        logic [7:0]  read_byte;
        logic        sound_interrupt;
        logic [7:0]  sound_latch_value;
        logic [15:0] scroll_x;
        logic [15:0] scroll_y;
        logic        flip_screen;
    } t_result;

endpackage

@@ sv/bbad_decode.sv @@
// address decode, read data select and register update for one bus transaction
`timescale 1ns / 1ps

module bbad_decode (
    input  bbad_pkg::t_item   i_item,
    input  bbad_pkg::t_state  i_state,
    input  logic [7:0]        i_dip_a,
    input  logic [7:0]        i_dip_b,
    output bbad_pkg::t_state  o_next_state,
    output bbad_pkg::t_result o_result
);

    logic [15:0]       a;
    logic [7:0]        d;
    bbad_pkg::t_region region;
    logic [16:0]       offset;
    logic [7:0]        rd;
    logic              irq;
    bbad_pkg::t_state  st;

    assign a = i_item.bus_address;
    assign d = i_item.write_byte;

    always_comb begin
        st     = i_state;
        region = bbad_pkg::REGION_UNMAPPED;
        offset = '0;
        rd     = '0;
        irq    = 1'b0;

        priority if (a < bbad_pkg::ADDR_SPRITE_BASE) begin
            region = bbad_pkg::REGION_WORK;
            offset = 17'(a);
        end else if (a < bbad_pkg::ADDR_FG_BASE) begin
            region = bbad_pkg::REGION_SPRITE;
            offset = 17'(a - bbad_pkg::ADDR_SPRITE_BASE);
        end else if (a < bbad_pkg::ADDR_BG_BASE) begin
            region = bbad_pkg::REGION_FG;
            offset = 17'(a - bbad_pkg::ADDR_FG_BASE);
        end else if (a < bbad_pkg::ADDR_IO_BASE) begin
            region = bbad_pkg::REGION_BG;
            offset = 17'(a - bbad_pkg::ADDR_BG_BASE);
        end else if (i_item.action == bbad_pkg::ACTION_READ) begin
            unique case (a)
                bbad_pkg::ADDR_SYSTEM: begin
                    region = bbad_pkg::REGION_INTERNAL;
                    rd     = i_item.system_port;
                end
                bbad_pkg::ADDR_PLAYER_ONE: begin
                    region = bbad_pkg::REGION_INTERNAL;
                    rd     = i_item.player_one_port;
                end
                bbad_pkg::ADDR_PLAYER_TWO: begin
                    region = bbad_pkg::REGION_INTERNAL;
                    rd     = i_item.player_two_port;
                end
                bbad_pkg::ADDR_DIP_A: begin
                    region = bbad_pkg::REGION_INTERNAL;
                    rd     = i_dip_a;
                end
                bbad_pkg::ADDR_DIP_B: begin
                    region = bbad_pkg::REGION_INTERNAL;
                    rd     = i_dip_b;
                end
                bbad_pkg::ADDR_WATCHDOG: begin
                    region = bbad_pkg::REGION_INTERNAL;
                end
                default: begin
                    if (a >= bbad_pkg::ADDR_FIXED_ROM) begin
                        region = bbad_pkg::REGION_ROM;
                        offset = 17'(a);
                    end else if (a >= bbad_pkg::ADDR_BANKED_ROM) begin
                        region = bbad_pkg::REGION_ROM;
                        // banks 4-7 alias the fixed page, 0-3 select an upper page
                        if (i_state.bank[2]) begin
                            offset = 17'(a);
                        end else begin
                            offset = bbad_pkg::ROM_BANK_BASE
                                   | {2'b00, i_state.bank[1:0], a[12:0]};
                        end
                    end
                end
            endcase
            if (region == bbad_pkg::REGION_INTERNAL) begin
                offset = 17'(a - bbad_pkg::ADDR_IO_BASE);
            end
        end else if (a[15:8] == bbad_pkg::ADDR_PAL_A_BASE[15:8]) begin
            region = bbad_pkg::REGION_PAL_A;
            offset = 17'(a[7:0]);
        end else if (a[15:8] == bbad_pkg::ADDR_PAL_B_BASE[15:8]) begin
            region = bbad_pkg::REGION_PAL_B;
            offset = 17'(a[7:0]);
        end else begin
            region = bbad_pkg::REGION_INTERNAL;
            unique case (a)
                bbad_pkg::ADDR_SOUND_LATCH: begin
                    st.latch = d;
                    irq      = 1'b1;
                end
                bbad_pkg::ADDR_SCROLL_X_LO: st.scroll_x[7:0]  = d;
                bbad_pkg::ADDR_SCROLL_X_HI: st.scroll_x[15:8] = d;
                bbad_pkg::ADDR_SCROLL_Y_LO: st.scroll_y[7:0]  = d;
                bbad_pkg::ADDR_SCROLL_Y_HI: st.scroll_y[15:8] = d;
                bbad_pkg::ADDR_FLIP:        st.flip = ~d[0];
                bbad_pkg::ADDR_BANK:        st.bank = d;
                bbad_pkg::ADDR_WATCHDOG,
                bbad_pkg::ADDR_COIN_A,
                bbad_pkg::ADDR_COIN_B: ;
                default: region = bbad_pkg::REGION_UNMAPPED;
            endcase
            if (region == bbad_pkg::REGION_INTERNAL) begin
                offset = 17'(a - bbad_pkg::ADDR_IO_BASE);
            end
        end

        if (region == bbad_pkg::REGION_UNMAPPED) begin
            offset = '0;
            rd     = bbad_pkg::UNMAPPED_DATA;
        end
    end

    assign o_next_state = st;

    always_comb begin
        o_result.region            = region;
        o_result.region_offset     = offset;
        o_result.read_byte         = rd;
        o_result.sound_interrupt   = irq;
        o_result.sound_latch_value = st.latch;
        o_result.scroll_x          = st.scroll_x;
        o_result.scroll_y          = st.scroll_y;
        o_result.flip_screen       = st.flip;
    end

endmodule

@@ sv/banked_bus_address_decoder.sv @@
// top level of the banked bus address decoder: input stage, state and result register
`timescale 1ns / 1ps

// Decodes one CPU bus transaction per clock into a region code, an offset inside that
// region and any read data held in the block, and applies writes to the bank, scroll,
// flip and sound latch registers. Each transaction passes through the input register
// and then the result register, and a new transaction is accepted every cycle while
// the result side takes results. The port values are sampled when the transaction is
// accepted. The register state reported with each result is the state after that
// transaction. DIP switch values should be written only while no transaction is in
// flight.
module banked_bus_address_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_byte,
    input  logic [7:0]  i_system_port,
    input  logic [7:0]  i_player_one_port,
    input  logic [7:0]  i_player_two_port,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_region,
    output logic [16:0] o_region_offset,
    output logic [7:0]  o_read_byte,
    output logic        o_sound_interrupt,
    output logic [7:0]  o_sound_latch_value,
    output logic [15:0] o_scroll_x,
    output logic [15:0] o_scroll_y,
    output logic        o_flip_screen
);

    logic              r_s1_valid;
    bbad_pkg::t_item   r_s1_item;
    bbad_pkg::t_state  r_state;
    logic [7:0]        r_dip_a;
    logic [7:0]        r_dip_b;
    logic              r_out_valid;
    bbad_pkg::t_result r_out;

    bbad_pkg::t_state  n_state;
    bbad_pkg::t_result n_out;
    logic              s1_advance;
    logic              in_accept;

    assign s1_advance = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    bbad_decode u_decode (
        .i_item       (r_s1_item),
        .i_state      (r_state),
        .i_dip_a      (r_dip_a),
        .i_dip_b      (r_dip_b),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_dip_a     <= 8'hFF;
            r_dip_b     <= 8'hFF;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bbad_pkg::CFG_DIP_A: r_dip_a <= i_cfg_data;
                    bbad_pkg::CFG_DIP_B: r_dip_b <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item.action          <= bbad_pkg::t_action'(i_action);
            r_s1_item.bus_address     <= i_bus_address;
            r_s1_item.write_byte      <= i_write_byte;
            r_s1_item.system_port     <= i_system_port;
            r_s1_item.player_one_port <= i_player_one_port;
            r_s1_item.player_two_port <= i_player_two_port;
        end
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_region            = r_out.region;
    assign o_region_offset     = r_out.region_offset;
    assign o_read_byte         = r_out.read_byte;
    assign o_sound_interrupt   = r_out.sound_interrupt;
    assign o_sound_latch_value = r_out.sound_latch_value;
    assign o_scroll_x          = r_out.scroll_x;
    assign o_scroll_y          = r_out.scroll_y;
    assign o_flip_screen       = r_out.flip_screen;

    // register state moves only with a transaction leaving the input stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_advance |=> $stable(r_state))
        else $error("register state changed without a transaction");

    a_irq_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sound_interrupt |-> o_region == bbad_pkg::REGION_INTERNAL)
        else $error("sound interrupt outside the internal region");

    a_unmapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_region == bbad_pkg::REGION_UNMAPPED
        |-> o_region_offset == 17'd0 && o_read_byte == bbad_pkg::UNMAPPED_DATA)
        else $error("unmapped result carries offset or data");

    a_rom_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_region == bbad_pkg::REGION_ROM
        |-> o_region_offset >= 17'(bbad_pkg::ADDR_BANKED_ROM))
        else $error("rom offset below the rom window");

    a_report_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sound_latch_value == r_state.latch
                     && o_scroll_x == r_state.scroll_x
                     && o_flip_screen == r_state.flip)
        else $error("reported state differs from held state");

endmodule

@@ tb/tb_banked_bus_address_decoder.sv @@
// self-checking testbench for the banked bus address decoder
`timescale 1ns / 1ps

module tb_banked_bus_address_decoder;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 350;
    localparam int NUM_PHASES   = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = bbad_pkg::CFG_DIP_A;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_action = bbad_pkg::ACTION_READ;
    logic [15:0] i_bus_address = 16'h0000;
    logic [7:0]  i_write_byte = 8'h00;
    logic [7:0]  i_system_port = 8'h00;
    logic [7:0]  i_player_one_port = 8'h00;
    logic [7:0]  i_player_two_port = 8'h00;
    logic        o_out_valid;
    wire         i_out_stall;
    logic [3:0]  o_region;
    logic [16:0] o_region_offset;
    logic [7:0]  o_read_byte;
    logic        o_sound_interrupt;
    logic [7:0]  o_sound_latch_value;
    logic [15:0] o_scroll_x;
    logic [15:0] o_scroll_y;
    logic        o_flip_screen;

    banked_bus_address_decoder u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_action            (i_action),
        .i_bus_address       (i_bus_address),
        .i_write_byte        (i_write_byte),
        .i_system_port       (i_system_port),
        .i_player_one_port   (i_player_one_port),
        .i_player_two_port   (i_player_two_port),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_region            (o_region),
        .o_region_offset     (o_region_offset),
        .o_read_byte         (o_read_byte),
        .o_sound_interrupt   (o_sound_interrupt),
        .o_sound_latch_value (o_sound_latch_value),
        .o_scroll_x          (o_scroll_x),
        .o_scroll_y          (o_scroll_y),
        .o_flip_screen       (o_flip_screen)
    );

    // shadow of the board registers and DIP switches
    bbad_pkg::t_state board_regs = '0;
    logic [7:0]       dip_a_shadow = 8'hFF;
    logic [7:0]       dip_b_shadow = 8'hFF;

    bbad_pkg::t_item   access_queue[$];
    bbad_pkg::t_result decoded_queue[$];
    bbad_pkg::t_item   next_access;

    int accesses_loaded = 0;
    int results_seen = 0;
    int errors = 0;
    int region_count[9] = '{default: 0};
    int irq_count = 0;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic rx_busy = 1'b0;
    logic rx_hold = 1'b0;
    logic hold_go = 1'b0;
    int   tx_gap = 0;
    int   rx_wait = 0;
    int   tx_run_left = 0;
    bit   tx_run_quiet = 1'b0;
    int   rx_run_left = 0;
    bit   rx_run_quiet = 1'b0;

    logic [15:0] reg_write_addr [10] = '{
        bbad_pkg::ADDR_SOUND_LATCH, bbad_pkg::ADDR_SCROLL_X_LO, bbad_pkg::ADDR_SCROLL_X_HI,
        bbad_pkg::ADDR_SCROLL_Y_LO, bbad_pkg::ADDR_SCROLL_Y_HI, bbad_pkg::ADDR_FLIP,
        bbad_pkg::ADDR_BANK, bbad_pkg::ADDR_WATCHDOG, bbad_pkg::ADDR_COIN_A,
        bbad_pkg::ADDR_COIN_B
    };

    assign i_out_stall = rx_hold | rx_busy;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // runs of back-to-back traffic and runs of random idling are drawn at random
    function automatic int draw_gap(inout int run_left, inout bit run_quiet);
        if (run_left == 0) begin
            run_left  = $urandom_range(10, 60);
            run_quiet = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return run_quiet ? 0 : int'($urandom_range(0, 10));
    endfunction

    // decodes one access against the shadow registers and returns the result
    function automatic bbad_pkg::t_result decode_access(input bbad_pkg::t_item acc);
        bbad_pkg::t_result r;
        logic [15:0]       a;
        logic [2:0]        bank;
        r        = '0;
        r.region = bbad_pkg::REGION_UNMAPPED;
        a        = acc.bus_address;
        if (a < bbad_pkg::ADDR_SPRITE_BASE) begin
            r.region        = bbad_pkg::REGION_WORK;
            r.region_offset = 17'(a);
        end else if (a < bbad_pkg::ADDR_FG_BASE) begin
            r.region        = bbad_pkg::REGION_SPRITE;
            r.region_offset = 17'(a - bbad_pkg::ADDR_SPRITE_BASE);
        end else if (a < bbad_pkg::ADDR_BG_BASE) begin
            r.region        = bbad_pkg::REGION_FG;
            r.region_offset = 17'(a - bbad_pkg::ADDR_FG_BASE);
        end else if (a < bbad_pkg::ADDR_IO_BASE) begin
            r.region        = bbad_pkg::REGION_BG;
            r.region_offset = 17'(a - bbad_pkg::ADDR_BG_BASE);
        end else if (acc.action == bbad_pkg::ACTION_READ) begin
            case (a)
                bbad_pkg::ADDR_SYSTEM: begin
                    r.region    = bbad_pkg::REGION_INTERNAL;
                    r.read_byte = acc.system_port;
                end
                bbad_pkg::ADDR_PLAYER_ONE: begin
                    r.region    = bbad_pkg::REGION_INTERNAL;
                    r.read_byte = acc.player_one_port;
                end
                bbad_pkg::ADDR_PLAYER_TWO: begin
                    r.region    = bbad_pkg::REGION_INTERNAL;
                    r.read_byte = acc.player_two_port;
                end
                bbad_pkg::ADDR_DIP_A: begin
                    r.region    = bbad_pkg::REGION_INTERNAL;
                    r.read_byte = dip_a_shadow;
                end
                bbad_pkg::ADDR_DIP_B: begin
                    r.region    = bbad_pkg::REGION_INTERNAL;
                    r.read_byte = dip_b_shadow;
                end
                bbad_pkg::ADDR_WATCHDOG: begin
                    r.region = bbad_pkg::REGION_INTERNAL;
                end
                default: begin
                    if (a >= bbad_pkg::ADDR_BANKED_ROM && a < bbad_pkg::ADDR_FIXED_ROM) begin
                        bank     = board_regs.bank[2:0];
                        r.region = bbad_pkg::REGION_ROM;
                        // lower four banks live above the fixed pages
                        if (!bank[2])
                            r.region_offset = bbad_pkg::ROM_BANK_BASE
                                              + {bank[1:0], 13'h0000}
                                              + 17'(a - bbad_pkg::ADDR_BANKED_ROM);
                        else
                            r.region_offset = 17'(a);
                    end else if (a >= bbad_pkg::ADDR_FIXED_ROM) begin
                        r.region        = bbad_pkg::REGION_ROM;
                        r.region_offset = 17'(a);
                    end
                end
            endcase
        end else if (a >= bbad_pkg::ADDR_PAL_A_BASE && a < bbad_pkg::ADDR_PAL_B_BASE) begin
            r.region        = bbad_pkg::REGION_PAL_A;
            r.region_offset = 17'(a - bbad_pkg::ADDR_PAL_A_BASE);
        end else if (a >= bbad_pkg::ADDR_PAL_B_BASE && a < bbad_pkg::ADDR_SOUND_LATCH) begin
            r.region        = bbad_pkg::REGION_PAL_B;
            r.region_offset = 17'(a - bbad_pkg::ADDR_PAL_B_BASE);
        end else begin
            r.region = bbad_pkg::REGION_INTERNAL;
            case (a)
                bbad_pkg::ADDR_SOUND_LATCH: begin
                    board_regs.latch  = acc.write_byte;
                    r.sound_interrupt = 1'b1;
                end
                bbad_pkg::ADDR_SCROLL_X_LO: board_regs.scroll_x[7:0]  = acc.write_byte;
                bbad_pkg::ADDR_SCROLL_X_HI: board_regs.scroll_x[15:8] = acc.write_byte;
                bbad_pkg::ADDR_SCROLL_Y_LO: board_regs.scroll_y[7:0]  = acc.write_byte;
                bbad_pkg::ADDR_SCROLL_Y_HI: board_regs.scroll_y[15:8] = acc.write_byte;
                bbad_pkg::ADDR_FLIP:        board_regs.flip = ~acc.write_byte[0];
                bbad_pkg::ADDR_BANK:        board_regs.bank = acc.write_byte;
                bbad_pkg::ADDR_WATCHDOG, bbad_pkg::ADDR_COIN_A, bbad_pkg::ADDR_COIN_B: ;
                default:          r.region = bbad_pkg::REGION_UNMAPPED;
            endcase
        end
        if (r.region == bbad_pkg::REGION_INTERNAL)
            r.region_offset = 17'(a - bbad_pkg::ADDR_IO_BASE);
        if (r.region == bbad_pkg::REGION_UNMAPPED) begin
            r.region_offset = '0;
            r.read_byte     = bbad_pkg::UNMAPPED_DATA;
        end
        r.sound_latch_value = board_regs.latch;
        r.scroll_x          = board_regs.scroll_x;
        r.scroll_y          = board_regs.scroll_y;
        r.flip_screen       = board_regs.flip;
        return r;
    endfunction

    function automatic bbad_pkg::t_item make_access(input bbad_pkg::t_action act,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] data);
        bbad_pkg::t_item it;
        it.action          = act;
        it.bus_address     = addr;
        it.write_byte      = data;
        it.system_port     = 8'($urandom);
        it.player_one_port = 8'($urandom);
        it.player_two_port = 8'($urandom);
        return it;
    endfunction

    task automatic load_access(input bbad_pkg::t_action act, input logic [15:0] addr,
                               input logic [7:0] data);
        access_queue.push_back(make_access(act, addr, data));
        accesses_loaded++;
    endtask

    task automatic load_directed();
        load_access(bbad_pkg::ACTION_READ,  16'h0000, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  16'h1DFF, 8'hFF);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SPRITE_BASE, 8'hFF);
        load_access(bbad_pkg::ACTION_READ,  16'h1FFF, 8'h00);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_FG_BASE, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  16'h2FFF, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_SYSTEM, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_PLAYER_ONE, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_PLAYER_TWO, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_DIP_A, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_DIP_B, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_WATCHDOG, 8'h00);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SOUND_LATCH, 8'hA5);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_X_LO, 8'hFF);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_X_HI, 8'h80);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_Y_LO, 8'h01);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_Y_HI, 8'hFE);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_FLIP, 8'h00);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_PAL_A_BASE, 8'h3C);
        load_access(bbad_pkg::ACTION_WRITE, 16'h39FF, 8'hC3);
        // palette is write-only, so this read is unmapped
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_PAL_B_BASE, 8'h00);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_BANK, 8'h03);
        load_access(bbad_pkg::ACTION_READ,  16'h5FFF, 8'h00);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_BANK, 8'hFC);
        load_access(bbad_pkg::ACTION_READ,  bbad_pkg::ADDR_BANKED_ROM, 8'h00);
        load_access(bbad_pkg::ACTION_READ,  16'hFFFF, 8'h00);
        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_FIXED_ROM, 8'h55);
        load_access(bbad_pkg::ACTION_READ,  16'h3005, 8'h00);
    endtask

    task automatic load_random_traffic(input int count);
        int          k;
        int          burst;
        logic [15:0] addr;
        k = 0;
        while (k < count) begin
            case ($urandom_range(0, 15))
                0, 1: begin
                    addr = 16'($urandom_range(0, 16'h2FFF));
                    load_access(bbad_pkg::t_action'($urandom_range(0, 1)), addr,
                                8'($urandom));
                    k++;
                end
                2: begin
                    addr = ($urandom_range(0, 5) == 5)
                         ? bbad_pkg::ADDR_WATCHDOG
                         : bbad_pkg::ADDR_IO_BASE + 16'($urandom_range(0, 4));
                    load_access(bbad_pkg::ACTION_READ, addr, 8'($urandom));
                    k++;
                end
                3, 4: begin
                    load_access(bbad_pkg::ACTION_WRITE, reg_write_addr[$urandom_range(0, 9)],
                                8'($urandom));
                    k++;
                end
                5: begin
                    addr = bbad_pkg::ADDR_PAL_A_BASE + 16'($urandom_range(0, 16'h01FF));
                    load_access(bbad_pkg::t_action'($urandom_range(0, 1)), addr,
                                8'($urandom));
                    k++;
                end
                6, 7: begin
                    // bank switch followed by reads through the window
                    load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_BANK, 8'($urandom));
                    burst = $urandom_range(1, 4);
                    for (int n = 0; n < burst; n++)
                        load_access(bbad_pkg::ACTION_READ,
                                    bbad_pkg::ADDR_BANKED_ROM
                                    + 16'($urandom_range(0, 16'h1FFF)),
                                    8'($urandom));
                    k += burst + 1;
                end
                8: begin
                    addr = 16'($urandom_range(bbad_pkg::ADDR_FIXED_ROM, 16'hFFFF));
                    load_access(bbad_pkg::ACTION_READ, addr, 8'($urandom));
                    k++;
                end
                9: begin
                    if ($urandom_range(0, 1)) begin
                        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_X_HI,
                                    8'($urandom));
                        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_X_LO,
                                    8'($urandom));
                    end else begin
                        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_Y_HI,
                                    8'($urandom));
                        load_access(bbad_pkg::ACTION_WRITE, bbad_pkg::ADDR_SCROLL_Y_LO,
                                    8'($urandom));
                    end
                    k += 2;
                end
                10: begin
                    load_access(bbad_pkg::t_action'($urandom_range(0, 1)), 16'($urandom),
                                8'($urandom));
                    k++;
                end
                11: begin
                    addr = bbad_pkg::ADDR_IO_BASE + 16'($urandom_range(0, 16'h0FFF));
                    load_access(bbad_pkg::t_action'($urandom_range(0, 1)), addr,
                                8'($urandom));
                    k++;
                end
                12: begin
                    addr = 16'($urandom_range(bbad_pkg::ADDR_BANKED_ROM, 16'hFFFF));
                    load_access(bbad_pkg::ACTION_WRITE, addr, 8'($urandom));
                    k++;
                end
                default: begin
                    addr = bbad_pkg::ADDR_BANKED_ROM + 16'($urandom_range(0, 16'h1FFF));
                    load_access(bbad_pkg::ACTION_READ, addr, 8'($urandom));
                    k++;
                end
            endcase
        end
    endtask

    // both switch banks written back to back while the block is idle
    task automatic write_dips(input logic [7:0] dip_a, input logic [7:0] dip_b);
        @(negedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_index  <= bbad_pkg::CFG_DIP_A;
        i_cfg_data   <= dip_a;
        dip_a_shadow = dip_a;
        @(negedge i_clk);
        i_cfg_index  <= bbad_pkg::CFG_DIP_B;
        i_cfg_data   <= dip_b;
        dip_b_shadow = dip_b;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_seen < accesses_loaded)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [16:0] got,
                               input logic [16:0] want);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // sender: presents queued transactions with a random gap after each one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (access_queue.size() > 0) begin
                next_access = access_queue.pop_front();
                i_action          <= next_access.action;
                i_bus_address     <= next_access.bus_address;
                i_write_byte      <= next_access.write_byte;
                i_system_port     <= next_access.system_port;
                i_player_one_port <= next_access.player_one_port;
                i_player_two_port <= next_access.player_two_port;
                i_in_valid        <= 1'b1;
                tx_gap = draw_gap(tx_run_left, tx_run_quiet);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // accepted transactions go through the predictor in order
    always @(posedge i_clk) begin : accept_side
        bbad_pkg::t_item   acc;
        bbad_pkg::t_result r;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            acc = '{action:          bbad_pkg::t_action'(i_action),
                    bus_address:     i_bus_address,
                    write_byte:      i_write_byte,
                    system_port:     i_system_port,
                    player_one_port: i_player_one_port,
                    player_two_port: i_player_two_port};
            r = decode_access(acc);
            decoded_queue.push_back(r);
            region_count[int'(r.region)]++;
            if (r.sound_interrupt)
                irq_count++;
        end
    end

    // receiver: random stall after each result taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_busy <= 1'b0;
        end else begin
            if (out_taken)
                rx_wait = draw_gap(rx_run_left, rx_run_quiet);
            if (rx_wait > 0) begin
                rx_wait--;
                rx_busy <= 1'b1;
            end else begin
                rx_busy <= 1'b0;
            end
        end
    end

    // long hold-off so the block backs up and stalls its input
    initial begin
        wait (hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : result_check
        bbad_pkg::t_result want;
        out_taken <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (decoded_queue.size() == 0) begin
                $error("result arrived with no transaction outstanding");
                errors++;
            end else begin
                want = decoded_queue.pop_front();
                check_field("region", 17'(o_region), 17'(want.region));
                check_field("region_offset", o_region_offset, want.region_offset);
                check_field("read_byte", 17'(o_read_byte), 17'(want.read_byte));
                check_field("sound_interrupt", 17'(o_sound_interrupt),
                            17'(want.sound_interrupt));
                check_field("sound_latch_value", 17'(o_sound_latch_value),
                            17'(want.sound_latch_value));
                check_field("scroll_x", 17'(o_scroll_x), 17'(want.scroll_x));
                check_field("scroll_y", 17'(o_scroll_y), 17'(want.scroll_y));
                check_field("flip_screen", 17'(o_flip_screen), 17'(want.flip_screen));
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: ;  // switches left at their reset value
                1: write_dips(8'h00, 8'h00);
                2: write_dips(8'($urandom), 8'($urandom));
                3: write_dips(8'hFF, 8'h00);
                default: write_dips(8'h00, 8'hFF);
            endcase
            if (phase == 0)
                load_directed();
            load_random_traffic(PHASE_ITEMS);
            if (phase == 2)
                hold_go = 1'b1;
            wait_drained();
        end

        if (decoded_queue.size() != 0) begin
            $error("%0d expected results never arrived", decoded_queue.size());
            errors++;
        end
        $display("%0d transactions over %0d switch settings: %0d memory, %0d palette",
                 results_seen, NUM_PHASES, region_count[0] + region_count[1] +
                 region_count[2] + region_count[3], region_count[4] + region_count[5]);
        $display("%0d rom, %0d internal, %0d unmapped, %0d sound latch writes",
                 region_count[6], region_count[7], region_count[8], irq_count);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog_timer
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bbad_pkg.sv
sv/bbad_decode.sv
sv/banked_bus_address_decoder.sv
tb/tb_banked_bus_address_decoder.sv
